### rtl/core/fifo_queue_with_position_insert_assert.svh
// Assertion macros for the position-insert queue.
`ifndef FIFO_QUEUE_WITH_POSITION_INSERT_ASSERT_SVH
`define FIFO_QUEUE_WITH_POSITION_INSERT_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define FQI_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fqi assertion failed");
// Condition that must never be true outside reset.
`define FQI_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("fqi forbidden condition seen");
`else
`define FQI_ASSERT(lbl, prop)
`define FQI_ASSERT_NEVER(lbl, cond)
`endif
`endif

### rtl/core/fqi_pkg.sv
// Shared types and constants for the position-insert queue.
package fqi_pkg;

	localparam int FQI_DEPTH = 16;

	// Request codes carried in the input tuser
	typedef enum logic [1:0] {
		REQ_ENQ = 2'd0,
		REQ_INS = 2'd1,
		REQ_DEQ = 2'd2
	} req_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// One stored record
	typedef struct packed {
		logic [31:0] start;
		logic [1:0]  kind;
		logic [15:0] id;
	} rec_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic deq;
	} cell_ctl_t;

endpackage

### rtl/core/fqi_cell.sv
// One slot of the record chain: holds, loads, or takes a neighbor's record.
module fqi_cell #(
	parameter int POS   = 0,
	parameter int CNT_W = 5
) (
	input  logic              clk,
	input  fqi_pkg::cell_ctl_t ctl,
	input  logic [CNT_W-1:0]  idx,
	input  fqi_pkg::rec_t     new_rec,
	input  fqi_pkg::rec_t     left_rec,
	input  fqi_pkg::rec_t     right_rec,
	output fqi_pkg::rec_t     rec
);
	import fqi_pkg::*;

	logic hit;
	logic after;
	rec_t rec_q;

	// Position of this cell relative to the insert point
	assign hit   = (idx == CNT_W'(POS));
	assign after = (idx < CNT_W'(POS));

	// Insert opens a gap at idx, dequeue moves everything toward the head
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (hit) begin
				rec_q <= new_rec;
			end else if (after) begin
				rec_q <= left_rec;
			end
		end else if (ctl.deq) begin
			rec_q <= right_rec;
		end
	end

	assign rec = rec_q;

endmodule

### rtl/core/fifo_queue_with_position_insert.sv
// Top level of the bounded record queue with insert at a chosen position.
//
// Usage: one request per input transfer on the s_ group. s_tuser selects
// enqueue at tail, insert at a one-based position, or dequeue of the head.
// Insert puts the record at zero-based index clamp(position-1, 1, count);
// into an empty queue it acts as enqueue. Each request yields exactly one
// result transfer on the m_ group: status, the dequeued record (zeros if
// none), the empty flag and the count after the request.
// The result is registered: it appears in the cycle after a request is taken.
// One request per cycle unless stalled; every slot of the DEPTH-cell chain
// shifts, loads or holds in the same cycle, so no request waits on another.
// A result register sits between the sides: while it is taken (or empty)
// a new request is accepted; if the receiver stalls, s_tready drops until
// the waiting result is taken. Reset empties the queue and the result
// register; slot contents are not cleared and are never read before written.
`include "fifo_queue_with_position_insert_assert.svh"
module fifo_queue_with_position_insert #(
	parameter int DEPTH = fqi_pkg::FQI_DEPTH,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int OUT_W = ((51 + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// item_id[15:0], item_kind[17:16], item_start[49:18], position[57:50]
	input  logic [63:0]      s_tdata,
	// req_type[1:0]
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// out_id[15:0], out_kind[17:16], out_start[49:18], is_empty_flag[50],
	// fill_count[51 +: CNT_W]
	output logic [OUT_W-1:0] m_tdata,
	// status[1:0], out_valid[2]
	output logic [2:0]       m_tuser
);
	import fqi_pkg::*;

	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	logic             accept;
	req_t             req;
	logic             is_add;
	logic             is_deq;
	logic             full;
	logic             empty;
	rec_t             new_rec;
	logic [7:0]       position;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] pos_m1;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] idx_c;
	logic [CNT_W-1:0] ins_idx;
	cell_ctl_t        ctl;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [1:0]       status_d;
	rec_t             out_rec_d;
	rec_t             cell_rec [DEPTH];

	logic             m_tvalid_q;
	logic [1:0]       status_q;
	logic             out_valid_q;
	rec_t             out_rec_q;
	logic [CNT_W-1:0] fill_q;

	// Input decode
	assign accept   = s_tvalid & s_tready;
	assign req      = req_t'(s_tuser);
	assign is_add   = (req == REQ_ENQ) || (req == REQ_INS);
	assign is_deq   = (req == REQ_DEQ);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign new_rec  = '{start: s_tdata[49:18], kind: s_tdata[17:16], id: s_tdata[15:0]};
	assign position = s_tdata[57:50];

	// Insert index: clamp(position-1, 1, count), tail for enqueue or an empty queue
	assign pos_w  = CMP_W'(position);
	assign pos_m1 = (pos_w <= CMP_W'(1)) ? CMP_W'(1) : pos_w - CMP_W'(1);
	assign cnt_w  = CMP_W'(count_q);
	assign idx_c  = (pos_m1 > cnt_w) ? cnt_w : pos_m1;

	always_comb begin
		if ((req == REQ_INS) && !empty) begin
			ins_idx = idx_c[CNT_W-1:0];
		end else begin
			ins_idx = count_q;
		end
	end

	// Chain command for this cycle
	assign ctl.ins = accept & is_add & ~full;
	assign ctl.deq = accept & is_deq & ~empty;

	// Next count and result
	always_comb begin
		count_d   = count_q;
		status_d  = ST_OK;
		out_rec_d = '0;
		if (is_add && full) begin
			status_d = ST_FULL;
		end else if (is_deq && empty) begin
			status_d = ST_EMPTY;
		end
		if (ctl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctl.deq) begin
			count_d   = count_q - CNT_W'(1);
			out_rec_d = cell_rec[0];
		end
	end

	// Record chain, slot 0 is the head
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rec_t left_rec;
		rec_t right_rec;
		if (i == 0) begin : g_head
			assign left_rec = new_rec;
		end else begin : g_mid_l
			assign left_rec = cell_rec[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_rec = cell_rec[i];
		end else begin : g_mid_r
			assign right_rec = cell_rec[i+1];
		end
		fqi_cell #(
			.POS   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (ins_idx),
			.new_rec   (new_rec),
			.left_rec  (left_rec),
			.right_rec (right_rec),
			.rec       (cell_rec[i])
		);
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// Result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			out_valid_q <= ctl.deq;
			out_rec_q   <= out_rec_d;
			fill_q      <= count_d;
		end
	end

	assign s_tready = ~m_tvalid_q | m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = {out_valid_q, status_q};
	assign m_tdata  = OUT_W'({fill_q, (fill_q == '0), out_rec_q.start,
		out_rec_q.kind, out_rec_q.id});

	// Checks
	`FQI_ASSERT_NEVER(a_count_range, count_q > CNT_W'(DEPTH))
	`FQI_ASSERT(a_deq_count, ctl.deq |=> count_q == $past(count_q) - CNT_W'(1))
	`FQI_ASSERT(a_full_drop, accept && is_add && full |=> count_q == $past(count_q))
	`FQI_ASSERT(a_valid_ok, m_tvalid_q && out_valid_q |-> status_q == ST_OK)

endmodule

### sim/testbench.sv
// Self-checking testbench for the record queue with insert at a chosen position.
module testbench;
	import fqi_pkg::*;

	localparam int CNT_W = $clog2(FQI_DEPTH + 1);
	localparam int OUT_W = ((51 + CNT_W + 7) / 8) * 8;
	// request code outside the defined set; the block answers ST_OK and leaves the queue as is
	localparam logic [1:0] REQ_RSVD = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1130;

	// one expected result transfer
	typedef struct {
		logic [1:0]       status;
		logic             out_valid;
		rec_t             rec;
		logic             empty;
		logic [CNT_W-1:0] count;
	} result_t;

	// one directed request; typed rows carry their own expected status and count
	typedef struct packed {
		logic [1:0]  req;
		logic [15:0] id;
		logic [1:0]  kind;
		logic [31:0] start;
		logic [7:0]  pos;
		logic        typed;
		logic [1:0]  exp_status;
		logic [4:0]  exp_count;
	} stim_row_t;

	localparam int PLAN_LEN = 23;
	stim_row_t plan [PLAN_LEN] = '{
		'{REQ_DEQ,  16'h0000, 2'd0, 32'h0000_0000, 8'd0,   1'b1, ST_EMPTY, 5'd0},
		'{REQ_RSVD, 16'h1234, 2'd1, 32'h0000_0001, 8'd4,   1'b1, ST_OK,    5'd0},
		'{REQ_INS,  16'h1111, 2'd1, 32'h0000_0001, 8'd5,   1'b0, ST_OK,    5'd0},
		'{REQ_ENQ,  16'hFFFF, 2'd3, 32'hFFFF_FFFF, 8'd255, 1'b0, ST_OK,    5'd0},
		'{REQ_ENQ,  16'h0000, 2'd0, 32'h0000_0000, 8'd0,   1'b0, ST_OK,    5'd0},
		'{REQ_INS,  16'h0006, 2'd2, 32'h8000_0000, 8'd0,   1'b0, ST_OK,    5'd0},
		'{REQ_INS,  16'h0007, 2'd1, 32'h7FFF_FFFF, 8'd1,   1'b0, ST_OK,    5'd0},
		'{REQ_INS,  16'h0008, 2'd3, 32'h5555_5555, 8'd2,   1'b0, ST_OK,    5'd0},
		'{REQ_INS,  16'h0009, 2'd0, 32'hAAAA_AAAA, 8'd255, 1'b0, ST_OK,    5'd0},
		'{REQ_INS,  16'h000A, 2'd2, 32'h0000_00A0, 8'd3,   1'b0, ST_OK,    5'd0},
		'{REQ_ENQ,  16'h000B, 2'd1, 32'h0000_00B0, 8'd0,   1'b0, ST_OK,    5'd0},
		'{REQ_INS,  16'h000C, 2'd2, 32'h0000_00C0, 8'd8,   1'b0, ST_OK,    5'd0},
		'{REQ_ENQ,  16'h000D, 2'd3, 32'h0000_00D0, 8'd0,   1'b0, ST_OK,    5'd0},
		'{REQ_INS,  16'h000E, 2'd0, 32'h0000_00E0, 8'd12,  1'b0, ST_OK,    5'd0},
		'{REQ_ENQ,  16'h000F, 2'd1, 32'h0000_00F0, 8'd0,   1'b0, ST_OK,    5'd0},
		'{REQ_INS,  16'h0010, 2'd2, 32'h0000_0100, 8'd128, 1'b0, ST_OK,    5'd0},
		'{REQ_ENQ,  16'h0011, 2'd3, 32'h0000_0110, 8'd0,   1'b0, ST_OK,    5'd0},
		'{REQ_INS,  16'h0012, 2'd0, 32'h0000_0120, 8'd16,  1'b0, ST_OK,    5'd0},
		'{REQ_ENQ,  16'hDEAD, 2'd1, 32'hDEAD_BEEF, 8'd0,   1'b1, ST_FULL,  5'd16},
		'{REQ_INS,  16'hBEEF, 2'd2, 32'hBEEF_DEAD, 8'd4,   1'b1, ST_FULL,  5'd16},
		'{REQ_RSVD, 16'h4321, 2'd3, 32'h0123_4567, 8'd9,   1'b1, ST_OK,    5'd16},
		'{REQ_DEQ,  16'h0000, 2'd0, 32'h0000_0000, 8'd0,   1'b0, ST_OK,    5'd0},
		'{REQ_DEQ,  16'hFFFF, 2'd3, 32'hFFFF_FFFF, 8'd255, 1'b0, ST_OK,    5'd0}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [63:0]      s_tdata = '0;
	logic [1:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [2:0]       m_tuser;

	rec_t    queue_image [$];
	result_t pending_results [$];
	result_t want;
	int      errors = 0;
	int      idle_cycles = 0;
	bit      quiet_span = 1'b0;

	fifo_queue_with_position_insert dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one request to the shadow queue and return the result it yields
	function automatic result_t apply_request(logic [1:0] req, rec_t rec, logic [7:0] pos);
		result_t r;
		int slot;
		r = '{status: ST_OK, out_valid: 1'b0, rec: '0, empty: 1'b0, count: '0};
		case (req)
			REQ_ENQ, REQ_INS: begin
				if (queue_image.size() >= FQI_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slot = queue_image.size();
					// insert index is clamped to [1, count]; empty queue appends
					if (req == REQ_INS && slot > 0) begin
						slot = (pos <= 8'd1) ? 1 : int'(pos) - 1;
						if (slot > queue_image.size())
							slot = queue_image.size();
					end
					queue_image.insert(slot, rec);
				end
			end
			REQ_DEQ: begin
				if (queue_image.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.out_valid = 1'b1;
					r.rec = queue_image.pop_front();
				end
			end
			default: ;
		endcase
		r.empty = (queue_image.size() == 0);
		r.count = CNT_W'(queue_image.size());
		return r;
	endfunction

	// Present one request, wait for the transfer, then record what it should yield
	task automatic send_request(logic [1:0] req, logic [15:0] id, logic [1:0] kind,
			logic [31:0] start, logic [7:0] pos, logic typed, logic [1:0] exp_status,
			logic [4:0] exp_count);
		rec_t rec;
		result_t r;
		rec.id = id;
		rec.kind = kind;
		rec.start = start;
		@(negedge clk);
		while (!quiet_span && $urandom_range(0, 99) < 6) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, pos, start, kind, id};
		s_tuser <= req;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = apply_request(req, rec, pos);
		if (typed) begin
			r = '{status: exp_status, out_valid: 1'b0, rec: '0,
				empty: (exp_count == 0), count: exp_count};
		end
		pending_results.push_back(r);
	endtask

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	// Receiver stalls at random except in the quiet span
	always @(negedge clk)
		m_tready <= quiet_span || ($urandom_range(0, 99) >= 6);

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, tuser %0h tdata %0h", $time, m_tuser, m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(m_tuser[1:0]));
				check_field("out_valid", 32'(want.out_valid), 32'(m_tuser[2]));
				check_field("out_id", 32'(want.rec.id), 32'(m_tdata[15:0]));
				check_field("out_kind", 32'(want.rec.kind), 32'(m_tdata[17:16]));
				check_field("out_start", want.rec.start, m_tdata[49:18]);
				check_field("is_empty_flag", 32'(want.empty), 32'(m_tdata[50]));
				check_field("fill_count", 32'(want.count), 32'(m_tdata[51 +: CNT_W]));
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int mode;
		int pick;
		int span;
		logic [1:0] req;
		logic [7:0] pos;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < PLAN_LEN; i++) begin
			send_request(plan[i].req, plan[i].id, plan[i].kind, plan[i].start, plan[i].pos,
				plan[i].typed, plan[i].exp_status, plan[i].exp_count);
		end

		// random traffic in bursts that lean toward filling, draining or neither
		mode = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet_span = (i >= 300 && i < 550);
			if (i == 700) begin
				// hold off until the queue has answered everything
				@(negedge clk);
				s_tvalid <= 1'b0;
				while (pending_results.size() != 0)
					@(negedge clk);
			end
			if (i % 40 == 0)
				mode = $urandom_range(0, 2);
			pick = $urandom_range(0, 99);
			if (pick < 2)
				req = REQ_RSVD;
			else if (pick < (mode == 0 ? 72 : mode == 1 ? 30 : 50))
				req = ($urandom_range(0, 1) == 0) ? REQ_ENQ : REQ_INS;
			else
				req = REQ_DEQ;
			span = queue_image.size() + 2;
			if ($urandom_range(0, 99) < 70)
				pos = 8'($urandom_range(0, span));
			else
				pos = 8'($urandom_range(0, 255));
			send_request(req, 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
				$urandom(), pos, 1'b0, ST_OK, 5'd0);
		end
		quiet_span = 1'b0;

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

### files.f
+incdir+rtl/core
rtl/core/fqi_pkg.sv
rtl/core/fqi_cell.sv
rtl/core/fifo_queue_with_position_insert.sv
sim/testbench.sv
